### sv/gcrssr_pkg.sv
// Package for the GCR sector stream reader.
// Holds field widths, command, status and parse phase codes, and register indexes.
// No dependencies.
`default_nettype none

package gcrssr_pkg;

	localparam int CMD_W        = 3;
	localparam int BYTE_W       = 8;
	localparam int ADDR_W       = 13;
	localparam int STATUS_W     = 4;
	localparam int COUNT_W      = 6;
	localparam int MASK_W       = 32;
	localparam int BCOUNT_W     = 9;
	localparam int CYL_W        = 7;
	localparam int SPT_W        = 6;
	localparam int PADDR_W      = 4;
	localparam int PDATA_W      = 32;
	localparam int STORE_DEPTH  = 8192;
	localparam int SECTOR_SLOTS = 32;
	localparam int SECTOR_BYTES = 256;
	localparam int SPT_RESET    = 21;

	localparam logic [BYTE_W-1:0] ID_HEADER  = 8'h08;
	localparam logic [BYTE_W-1:0] ID_DATA    = 8'h07;
	localparam logic [BYTE_W-1:0] GAP_BYTE   = 8'h0f;
	localparam int                HEADER_LEN = 5;
	localparam int                TRAILER_LEN = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_SYNC   = 3'd0,
		CMD_BYTE   = 3'd1,
		CMD_ERROR  = 3'd2,
		CMD_HWRITE = 3'd3,
		CMD_HREAD  = 3'd4,
		CMD_CLEAR  = 3'd5
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_BUSY      = 4'd0,
		ST_HDR_OK    = 4'd1,
		ST_HDR_SUM   = 4'd2,
		ST_WRONG_TRK = 4'd3,
		ST_IGNORED   = 4'd4,
		ST_BAD_ID    = 4'd5,
		ST_NO_HDR    = 4'd6,
		ST_TRAIL_BAD = 4'd7,
		ST_READ      = 4'd8,
		ST_DATA_SUM  = 4'd9,
		ST_MISMATCH  = 4'd10,
		ST_HOST      = 4'd11
	} status_t;

	typedef enum logic [2:0] {
		PH_WAIT    = 3'd0,
		PH_ID      = 3'd1,
		PH_HEADER  = 3'd2,
		PH_TRAILER = 3'd3,
		PH_DATA    = 3'd4,
		PH_DSUM    = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		REG_CYLINDER = 2'd0,
		REG_SPT      = 2'd1,
		REG_VERIFY   = 2'd2
	} reg_idx_t;

endpackage

`default_nettype wire

### sv/gcrssr_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Width and depth are parameters; no dependencies.
`default_nettype none

module gcrssr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### sv/gcr_sector_stream_reader.sv
// Top level of the GCR sector stream reader: parser, sector statistics and config port.
// Depends on gcrssr_pkg and gcrssr_ram (the 8192-byte sector store).
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------------------
//  input    | in_valid / in_stall     | cmd, value, store_address
//  output   | out_valid / out_stall   | status, sector_number, read_data, totals, bits
//  config   | psel/penable/pwrite     | paddr, pwdata, prdata, pready
//
// One beat is accepted per cycle while in_stall is low, and is then held in the input stage.
// The store is read and written on accept; the result is registered when the item moves on.
// A stalled output blocks the item behind it, which then stalls the input.
// Reset clears parse state and statistics and presets the registers; store is undefined.
`default_nettype none

module gcr_sector_stream_reader (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [gcrssr_pkg::CMD_W-1:0]     cmd,
	input  wire logic [gcrssr_pkg::BYTE_W-1:0]    value,
	input  wire logic [gcrssr_pkg::ADDR_W-1:0]    store_address,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [gcrssr_pkg::STATUS_W-1:0]       status,
	output logic [gcrssr_pkg::BYTE_W-1:0]         sector_number,
	output logic [gcrssr_pkg::BYTE_W-1:0]         read_data,
	output logic [gcrssr_pkg::COUNT_W-1:0]        detected_total,
	output logic [gcrssr_pkg::COUNT_W-1:0]        read_total,
	output logic [gcrssr_pkg::MASK_W-1:0]         detected_bits,
	output logic [gcrssr_pkg::MASK_W-1:0]         read_bits,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [gcrssr_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [gcrssr_pkg::PDATA_W-1:0]   pwdata,
	output logic [gcrssr_pkg::PDATA_W-1:0]        prdata,
	output logic                                  pready
);

	import gcrssr_pkg::*;

	logic [CYL_W-1:0] cyl_q;
	logic [SPT_W-1:0] spt_q;
	logic             verify_q;

	phase_t              ph_q, ph_n;
	logic [BCOUNT_W-1:0] bc_q, bc_n;
	logic [BYTE_W-1:0]   x_q, x_n;
	logic [BYTE_W-1:0]   hs_q, hs_n;
	logic [BYTE_W-1:0]   ht_q, ht_n;
	logic                hv_q, hv_n;
	logic [MASK_W-1:0]   seen_q, seen_n, done_q, done_n;
	logic [COUNT_W-1:0]  seen_cnt_q, seen_cnt_n, done_cnt_q, done_cnt_n;

	cmd_t              cmd_s1;
	logic [BYTE_W-1:0] val_s1;
	logic              v_s1;

	status_t           st_n;
	logic [BYTE_W-1:0] rd_n;

	logic [STATUS_W-1:0] status_q;
	logic [BYTE_W-1:0]   sector_q, rdata_q;
	logic                out_v_q;

	logic              fire, accept, cfg_wr;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [BYTE_W-1:0] ram_rdata;
	logic [BYTE_W-1:0] expected_trk;
	logic [BCOUNT_W-1:0] bc_inc;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cyl_q    <= '0;
			spt_q    <= SPT_W'(SPT_RESET);
			verify_q <= 1'b0;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[3:2]))
				REG_CYLINDER: cyl_q    <= pwdata[CYL_W-1:0];
				REG_SPT:      spt_q    <= pwdata[SPT_W-1:0];
				REG_VERIFY:   verify_q <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_CYLINDER: prdata = PDATA_W'(cyl_q);
			REG_SPT:      prdata = PDATA_W'(spt_q);
			REG_VERIFY:   prdata = PDATA_W'(verify_q);
			default:      prdata = '0;
		endcase
	end

	assign fire     = v_s1 && (!out_v_q || !out_stall);
	assign in_stall = v_s1 && out_v_q && out_stall;
	assign accept   = in_valid && !in_stall;

	assign expected_trk = BYTE_W'(cyl_q[CYL_W-1:1]) + 8'd1;
	assign bc_inc       = bc_q + 9'd1;

	always_comb begin
		ph_n       = ph_q;
		bc_n       = bc_q;
		x_n        = x_q;
		hs_n       = hs_q;
		ht_n       = ht_q;
		hv_n       = hv_q;
		seen_n     = seen_q;
		done_n     = done_q;
		seen_cnt_n = seen_cnt_q;
		done_cnt_n = done_cnt_q;
		st_n       = ST_BUSY;
		rd_n       = '0;
		if (fire) begin
			case (cmd_s1)
				CMD_SYNC: begin
					ph_n = PH_ID;
					bc_n = '0;
				end
				CMD_BYTE: begin
					case (ph_q)
						PH_ID: begin
							if (val_s1 == ID_HEADER) begin
								ph_n = PH_HEADER;
								bc_n = '0;
								x_n  = '0;
								hv_n = 1'b0;
							end else if (val_s1 == ID_DATA) begin
								if (hv_q) begin
									ph_n = PH_DATA;
									bc_n = '0;
									x_n  = '0;
								end else begin
									st_n = ST_NO_HDR;
									ph_n = PH_WAIT;
								end
							end else begin
								st_n = ST_BAD_ID;
								ph_n = PH_WAIT;
							end
						end
						PH_HEADER: begin
							x_n  = x_q ^ val_s1;
							bc_n = bc_inc;
							if (bc_q == 9'd1) begin
								hs_n = val_s1;
							end
							if (bc_q == 9'd2) begin
								ht_n = val_s1;
							end
							if (bc_inc >= BCOUNT_W'(HEADER_LEN)) begin
								bc_n = '0;
								if (x_n != '0) begin
									st_n = ST_HDR_SUM;
									hv_n = 1'b0;
									ph_n = PH_WAIT;
								end else begin
									if (hs_n < BYTE_W'(SECTOR_SLOTS) && hs_n < 8'd32 &&
									    !seen_q[hs_n[4:0]]) begin
										seen_n[hs_n[4:0]] = 1'b1;
										seen_cnt_n        = seen_cnt_q + 6'd1;
									end
									if (ht_n != expected_trk) begin
										st_n = ST_WRONG_TRK;
										hv_n = 1'b0;
										ph_n = PH_WAIT;
									end else if (hs_n >= BYTE_W'(spt_q)) begin
										st_n = ST_IGNORED;
										hv_n = 1'b0;
										ph_n = PH_TRAILER;
									end else begin
										st_n = ST_HDR_OK;
										hv_n = 1'b1;
										ph_n = PH_TRAILER;
									end
								end
							end
						end
						PH_TRAILER: begin
							if (val_s1 != GAP_BYTE) begin
								st_n = ST_TRAIL_BAD;
							end
							bc_n = bc_inc;
							if (bc_inc >= BCOUNT_W'(TRAILER_LEN)) begin
								bc_n = '0;
								ph_n = PH_WAIT;
							end
						end
						PH_DATA: begin
							if (verify_q && ram_rdata != val_s1) begin
								st_n = ST_MISMATCH;
								bc_n = '0;
								ph_n = PH_WAIT;
							end else begin
								x_n  = x_q ^ val_s1;
								bc_n = bc_inc;
								if (bc_inc >= BCOUNT_W'(SECTOR_BYTES)) begin
									bc_n = '0;
									ph_n = PH_DSUM;
								end
							end
						end
						PH_DSUM: begin
							x_n = x_q ^ val_s1;
							if (x_n == '0) begin
								if (hs_q < BYTE_W'(SECTOR_SLOTS) && hs_q < 8'd32 &&
								    !done_q[hs_q[4:0]]) begin
									done_n[hs_q[4:0]] = 1'b1;
									done_cnt_n        = done_cnt_q + 6'd1;
								end
								st_n = ST_READ;
							end else begin
								st_n = ST_DATA_SUM;
							end
							hv_n = 1'b0;
							ph_n = PH_WAIT;
						end
						default: ph_n = PH_WAIT;
					endcase
				end
				CMD_ERROR: begin
					ph_n = PH_WAIT;
					bc_n = '0;
				end
				CMD_HWRITE: begin
					rd_n = val_s1;
					st_n = ST_HOST;
				end
				CMD_HREAD: begin
					rd_n = ram_rdata;
					st_n = ST_HOST;
				end
				CMD_CLEAR: begin
					seen_n     = '0;
					done_n     = '0;
					seen_cnt_n = '0;
					done_cnt_n = '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Store access uses the parse state as it stands once the item ahead is finished.
	always_comb begin
		if (cmd == CMD_HWRITE || cmd == CMD_HREAD) begin
			ram_addr = store_address;
		end else begin
			ram_addr = {hs_n[4:0], bc_n[7:0]};
		end
		ram_we = accept && (cmd == CMD_HWRITE ||
		                    (cmd == CMD_BYTE && ph_n == PH_DATA && !verify_q));
	end

	gcrssr_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_addr),
		.wdata(value),
		.re   (accept),
		.raddr(ram_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q       <= PH_WAIT;
			bc_q       <= '0;
			x_q        <= '0;
			hs_q       <= '0;
			ht_q       <= '0;
			hv_q       <= 1'b0;
			seen_q     <= '0;
			done_q     <= '0;
			seen_cnt_q <= '0;
			done_cnt_q <= '0;
			v_s1       <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			ph_q       <= ph_n;
			bc_q       <= bc_n;
			x_q        <= x_n;
			hs_q       <= hs_n;
			ht_q       <= ht_n;
			hv_q       <= hv_n;
			seen_q     <= seen_n;
			done_q     <= done_n;
			seen_cnt_q <= seen_cnt_n;
			done_cnt_q <= done_cnt_n;
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (fire) begin
				v_s1 <= 1'b0;
			end
			if (fire) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_t'(cmd);
			val_s1 <= value;
		end
		if (fire) begin
			status_q <= st_n;
			sector_q <= hs_n;
			rdata_q  <= rd_n;
		end
	end

	assign out_valid      = out_v_q;
	assign status         = status_q;
	assign sector_number  = sector_q;
	assign read_data      = rdata_q;
	assign detected_total = seen_cnt_q;
	assign read_total     = done_cnt_q;
	assign detected_bits  = seen_q;
	assign read_bits      = done_q;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1)
		else $error("Input stalled with no item waiting.");

	a_fire_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_v_q)
		else $error("Processed item produced no result.");

	a_seen_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(seen_q) == 32'(seen_cnt_q))
		else $error("Detected count disagrees with detected mask.");

	a_done_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(done_q) == 32'(done_cnt_q))
		else $error("Read count disagrees with read mask.");

	a_data_has_header: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q == PH_DATA) |-> (hv_q && !bc_q[BCOUNT_W-1]))
		else $error("Data phase without a valid header or past the sector end.");

endmodule

`default_nettype wire

### sim/gcr_sector_stream_reader_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for gcr_sector_stream_reader: directed rows, then random disk
// streams of headers, data blocks, host store access and noise under several register settings.
// Depends on gcrssr_pkg and the RTL of the reader; every beat is checked against a local predictor.

module gcr_sector_stream_reader_test;

	import gcrssr_pkg::*;

	localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;
	localparam int DIRECTED_ROWS = 29;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [BYTE_W-1:0] value;
		logic [ADDR_W-1:0] addr;
	} disk_beat_t;

	typedef struct packed {
		status_t            st;
		logic [BYTE_W-1:0]  sec;
		logic [BYTE_W-1:0]  rd;
		logic [COUNT_W-1:0] dcnt;
		logic [COUNT_W-1:0] rcnt;
		logic [MASK_W-1:0]  dbits;
		logic [MASK_W-1:0]  rbits;
	} sector_report_t;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [BYTE_W-1:0] value;
		logic [ADDR_W-1:0] addr;
		logic              typed;
		status_t           st;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [CMD_W-1:0] cmd;
	logic [BYTE_W-1:0] value;
	logic [ADDR_W-1:0] store_address;
	logic out_valid;
	logic out_stall;
	logic [STATUS_W-1:0] status;
	logic [BYTE_W-1:0] sector_number;
	logic [BYTE_W-1:0] read_data;
	logic [COUNT_W-1:0] detected_total;
	logic [COUNT_W-1:0] read_total;
	logic [MASK_W-1:0] detected_bits;
	logic [MASK_W-1:0] read_bits;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	gcr_sector_stream_reader u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.value(value),
		.store_address(store_address),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.sector_number(sector_number),
		.read_data(read_data),
		.detected_total(detected_total),
		.read_total(read_total),
		.detected_bits(detected_bits),
		.read_bits(read_bits),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	logic [CYL_W-1:0] cyl_reg = '0;
	logic [SPT_W-1:0] spt_reg = SPT_W'(SPT_RESET);
	logic verify_reg = 1'b0;

	phase_t phase = PH_WAIT;
	logic [BCOUNT_W-1:0] bcnt = '0;
	logic [BYTE_W-1:0] rxor = '0;
	logic [BYTE_W-1:0] hsec = '0;
	logic [BYTE_W-1:0] htrk = '0;
	logic hvalid = 1'b0;
	logic [BYTE_W-1:0] store_shadow [STORE_DEPTH];
	bit written [STORE_DEPTH];
	int written_list [$];
	logic [MASK_W-1:0] seen_bits = '0;
	logic [MASK_W-1:0] done_bits = '0;
	logic [COUNT_W-1:0] seen_cnt = '0;
	logic [COUNT_W-1:0] done_cnt = '0;

	sector_report_t pending_reports [$];
	sector_report_t want;
	plan_row_t plan [DIRECTED_ROWS];
	int errors = 0;
	int sent = 0;
	int checked = 0;
	int settings = 0;
	int burst_left = 0;
	int hold_left = 0;
	int hist [16];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Timeout with %0d results outstanding.", pending_reports.size());
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic flag_error(input string what, input logic [31:0] got, input logic [31:0] exp_v);
		$display("%0t: mismatch in %s: got %h, expected %h", $realtime, what, got, exp_v);
		errors++;
	endtask

	function automatic logic [ADDR_W-1:0] data_addr();
		return ADDR_W'(int'(hsec) * SECTOR_BYTES + int'(bcnt));
	endfunction

	function automatic void note_store(input logic [ADDR_W-1:0] a, input logic [BYTE_W-1:0] v);
		store_shadow[a] = v;
		if (!written[a]) begin
			written[a] = 1'b1;
			written_list.push_back(int'(a));
		end
	endfunction

	function automatic void mark_slot(input bit done, input logic [BYTE_W-1:0] s);
		if (int'(s) < SECTOR_SLOTS && int'(s) < 32) begin
			if (done) begin
				if (!done_bits[s[4:0]]) begin
					done_bits[s[4:0]] = 1'b1;
					done_cnt++;
				end
			end else if (!seen_bits[s[4:0]]) begin
				seen_bits[s[4:0]] = 1'b1;
				seen_cnt++;
			end
		end
	endfunction

	function automatic status_t take_disk_byte(input logic [BYTE_W-1:0] v);
		status_t st;
		logic [ADDR_W-1:0] a;
		st = ST_BUSY;
		case (phase)
			PH_ID: begin
				if (v == ID_HEADER) begin
					phase = PH_HEADER;
					bcnt = '0;
					rxor = '0;
					hvalid = 1'b0;
				end else if (v == ID_DATA) begin
					if (hvalid) begin
						phase = PH_DATA;
						bcnt = '0;
						rxor = '0;
					end else begin
						st = ST_NO_HDR;
						phase = PH_WAIT;
					end
				end else begin
					st = ST_BAD_ID;
					phase = PH_WAIT;
				end
			end
			PH_HEADER: begin
				rxor ^= v;
				if (bcnt == 1) hsec = v;
				if (bcnt == 2) htrk = v;
				bcnt++;
				if (bcnt >= HEADER_LEN) begin
					bcnt = '0;
					if (rxor != 0) begin
						st = ST_HDR_SUM;
						hvalid = 1'b0;
						phase = PH_WAIT;
					end else begin
						mark_slot(1'b0, hsec);
						if (int'(htrk) != int'(cyl_reg >> 1) + 1) begin
							st = ST_WRONG_TRK;
							hvalid = 1'b0;
							phase = PH_WAIT;
						end else if (int'(hsec) >= int'(spt_reg)) begin
							st = ST_IGNORED;
							hvalid = 1'b0;
							phase = PH_TRAILER;
						end else begin
							st = ST_HDR_OK;
							hvalid = 1'b1;
							phase = PH_TRAILER;
						end
					end
				end
			end
			PH_TRAILER: begin
				if (v != GAP_BYTE) st = ST_TRAIL_BAD;
				bcnt++;
				if (bcnt >= TRAILER_LEN) begin
					bcnt = '0;
					phase = PH_WAIT;
				end
			end
			PH_DATA: begin
				a = data_addr();
				if (verify_reg && store_shadow[a] != v) begin
					st = ST_MISMATCH;
					bcnt = '0;
					phase = PH_WAIT;
				end else begin
					if (!verify_reg) note_store(a, v);
					rxor ^= v;
					bcnt++;
					if (bcnt >= SECTOR_BYTES) begin
						bcnt = '0;
						phase = PH_DSUM;
					end
				end
			end
			PH_DSUM: begin
				rxor ^= v;
				if (rxor == 0) begin
					mark_slot(1'b1, hsec);
					st = ST_READ;
				end else begin
					st = ST_DATA_SUM;
				end
				hvalid = 1'b0;
				phase = PH_WAIT;
			end
			default: phase = PH_WAIT;
		endcase
		return st;
	endfunction

	function automatic sector_report_t advance_reader(input disk_beat_t b);
		sector_report_t r;
		r = '0;
		r.st = ST_BUSY;
		case (b.cmd)
			CMD_SYNC: begin
				phase = PH_ID;
				bcnt = '0;
			end
			CMD_BYTE: r.st = take_disk_byte(b.value);
			CMD_ERROR: begin
				phase = PH_WAIT;
				bcnt = '0;
			end
			CMD_HWRITE: begin
				note_store(b.addr, b.value);
				r.rd = b.value;
				r.st = ST_HOST;
			end
			CMD_HREAD: begin
				r.rd = store_shadow[b.addr];
				r.st = ST_HOST;
			end
			CMD_CLEAR: begin
				seen_bits = '0;
				done_bits = '0;
				seen_cnt = '0;
				done_cnt = '0;
			end
			default: ;
		endcase
		r.sec = hsec;
		r.dcnt = seen_cnt;
		r.rcnt = done_cnt;
		r.dbits = seen_bits;
		r.rbits = done_bits;
		return r;
	endfunction

	function automatic bit slot_full(input int s);
		bit full;
		full = 1'b1;
		for (int i = 0; i < SECTOR_BYTES; i++) begin
			if (!written[ADDR_W'(s * SECTOR_BYTES + i)]) full = 1'b0;
		end
		return full;
	endfunction

	// Never read a store entry that has not been written, by host or by a verify compare.
	task automatic send_beat(input logic [CMD_W-1:0] c, input logic [BYTE_W-1:0] v,
			input logic [ADDR_W-1:0] a);
		disk_beat_t b;
		int g;
		b.cmd = c;
		b.value = v;
		b.addr = a;
		if (b.cmd == CMD_HREAD && !written[b.addr]) begin
			if (written_list.size() == 0) b.cmd = CMD_HWRITE;
			else b.addr = ADDR_W'(written_list[$urandom_range(0, written_list.size() - 1)]);
		end
		if (b.cmd == CMD_BYTE && verify_reg && phase == PH_DATA && !written[data_addr()]) begin
			b.cmd = CMD_ERROR;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		cmd <= b.cmd;
		value <= b.value;
		store_address <= b.addr;
		do @(posedge clk); while (in_stall);
		pending_reports.push_back(advance_reader(b));
		sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 24);
			g = $urandom_range(1, 6);
			repeat (g) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
	endtask

	task automatic send_disk(input logic [BYTE_W-1:0] v);
		send_beat(CMD_BYTE, v, ADDR_W'($urandom_range(0, STORE_DEPTH - 1)));
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_CYLINDER: cyl_reg = val[CYL_W-1:0];
			REG_SPT: spt_reg = val[SPT_W-1:0];
			REG_VERIFY: verify_reg = val[0];
			default: ;
		endcase
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata != val) flag_error("register read back", prdata, val);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic send_header(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] trk,
			input bit bad_sum, input bit loose_trailer);
		logic [BYTE_W-1:0] id2;
		logic [BYTE_W-1:0] id1;
		logic [BYTE_W-1:0] chk;
		id2 = BYTE_W'($urandom_range(0, 255));
		id1 = BYTE_W'($urandom_range(0, 255));
		chk = s ^ trk ^ id2 ^ id1;
		if (bad_sum) chk ^= BYTE_W'($urandom_range(1, 255));
		send_beat(CMD_SYNC, '0, '0);
		send_disk(ID_HEADER);
		send_disk(chk);
		send_disk(s);
		send_disk(trk);
		send_disk(id2);
		send_disk(id1);
		repeat (TRAILER_LEN) begin
			if (loose_trailer && $urandom_range(0, 1) == 0) send_disk(BYTE_W'($urandom_range(0, 255)));
			else send_disk(GAP_BYTE);
		end
	endtask

	task automatic random_header();
		logic [BYTE_W-1:0] s;
		logic [BYTE_W-1:0] trk;
		s = ($urandom_range(0, 9) < 6) ? BYTE_W'($urandom_range(0, int'(spt_reg) - 1))
			: BYTE_W'($urandom_range(0, 255));
		trk = ($urandom_range(0, 9) < 8) ? BYTE_W'(int'(cyl_reg >> 1) + 1)
			: BYTE_W'($urandom_range(0, 255));
		send_header(s, trk, $urandom_range(0, 6) == 0, $urandom_range(0, 5) == 0);
	endtask

	task automatic host_burst();
		int n;
		n = $urandom_range(1, 4);
		repeat (n) begin
			if ($urandom_range(0, 1) == 0) begin
				send_beat(CMD_HWRITE, BYTE_W'($urandom_range(0, 255)),
					ADDR_W'($urandom_range(0, STORE_DEPTH - 1)));
			end else begin
				send_beat(CMD_HREAD, '0, ADDR_W'($urandom_range(0, STORE_DEPTH - 1)));
			end
		end
	endtask

	task automatic noise_burst();
		int n;
		n = $urandom_range(1, 6);
		repeat (n) begin
			if ($urandom_range(0, 2) == 0) begin
				send_beat(CMD_SYNC, '0, '0);
				send_disk(($urandom_range(0, 1) == 0) ? ID_DATA : BYTE_W'($urandom_range(0, 255)));
			end else begin
				send_beat(CMD_W'($urandom_range(0, 7)), BYTE_W'($urandom_range(0, 255)),
					ADDR_W'($urandom_range(0, STORE_DEPTH - 1)));
			end
		end
	endtask

	task automatic data_block();
		int s;
		int cut;
		int bad_at;
		bit found;
		logic [BYTE_W-1:0] d;
		logic [BYTE_W-1:0] sum;
		found = 1'b0;
		s = 0;
		if (verify_reg) begin
			repeat (8) begin
				if (!found) begin
					s = $urandom_range(0, int'(spt_reg) - 1);
					found = slot_full(s);
				end
			end
		end else begin
			s = $urandom_range(0, int'(spt_reg) - 1);
			found = 1'b1;
		end
		if (!found) begin
			random_header();
			return;
		end
		send_header(BYTE_W'(s), BYTE_W'(int'(cyl_reg >> 1) + 1), 1'b0, 1'b0);
		send_beat(CMD_SYNC, '0, '0);
		send_disk(ID_DATA);
		bad_at = (verify_reg && $urandom_range(0, 2) == 0) ? $urandom_range(0, SECTOR_BYTES - 1) : -1;
		cut = ($urandom_range(0, 11) == 0) ? $urandom_range(0, SECTOR_BYTES - 1) : SECTOR_BYTES;
		sum = '0;
		for (int i = 0; i < SECTOR_BYTES; i++) begin
			if (i == cut) begin
				send_beat(($urandom_range(0, 1) == 0) ? CMD_SYNC : CMD_ERROR, '0, '0);
				return;
			end
			if ($urandom_range(0, 63) == 0) host_burst();
			if ($urandom_range(0, 199) == 0) send_beat(CMD_CLEAR, '0, '0);
			d = verify_reg ? store_shadow[ADDR_W'(s * SECTOR_BYTES + i)] : BYTE_W'($urandom_range(0, 255));
			if (i == bad_at) begin
				send_disk(d ^ BYTE_W'($urandom_range(1, 255)));
				return;
			end
			send_disk(d);
			sum ^= d;
		end
		if ($urandom_range(0, 3) == 0) sum ^= BYTE_W'(1 << $urandom_range(0, 7));
		send_disk(sum);
	endtask

	task automatic run_phase(input int cyl, input int spt, input bit ver, input int budget,
			input bit squeeze);
		int start;
		int pick;
		drain();
		write_reg(REG_CYLINDER, PDATA_W'(cyl));
		write_reg(REG_SPT, PDATA_W'(spt));
		write_reg(REG_VERIFY, PDATA_W'(ver));
		settings++;
		start = sent;
		if (squeeze) begin
			hold_left = 150;
			data_block();
			data_block();
		end
		while (sent - start < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) data_block();
			else if (pick < 65) random_header();
			else if (pick < 78) host_burst();
			else noise_burst();
		end
	endtask

	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			int mode;
			int len;
			mode = $urandom_range(0, 3);
			len = $urandom_range(10, 60);
			repeat (len) begin
				@(negedge clk);
				if (hold_left > 0) begin
					out_stall <= 1'b1;
					hold_left--;
				end else begin
					case (mode)
						0: out_stall <= 1'b0;
						1: out_stall <= $urandom_range(0, 1);
						2: out_stall <= ($urandom_range(0, 3) == 0);
						default: out_stall <= ($urandom_range(0, 5) != 0);
					endcase
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_reports.size() == 0) begin
				flag_error("result with nothing pending, status", status, '0);
			end else begin
				want = pending_reports.pop_front();
				checked++;
				hist[int'(want.st)]++;
				if (status != want.st) flag_error("status", status, want.st);
				if (sector_number != want.sec) flag_error("sector_number", sector_number, want.sec);
				if (read_data != want.rd) flag_error("read_data", read_data, want.rd);
				if (detected_total != want.dcnt) flag_error("detected_total", detected_total, want.dcnt);
				if (read_total != want.rcnt) flag_error("read_total", read_total, want.rcnt);
				if (detected_bits != want.dbits) flag_error("detected_bits", detected_bits, want.dbits);
				if (read_bits != want.rbits) flag_error("read_bits", read_bits, want.rbits);
			end
		end
	end

	initial begin
		sector_report_t last;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_SYNC;
		value = '0;
		store_address = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		for (int i = 0; i < 16; i++) hist[i] = 0;
		plan = '{
			'{CMD_BYTE,   8'h55,     13'h0000, 1'b1, ST_BUSY},
			'{CMD_CLEAR,  8'h00,     13'h0000, 1'b1, ST_BUSY},
			'{CMD_SPARE6, 8'hff,     13'h1fff, 1'b1, ST_BUSY},
			'{CMD_SPARE7, 8'h00,     13'h0000, 1'b1, ST_BUSY},
			'{CMD_HWRITE, 8'hff,     13'h1fff, 1'b1, ST_HOST},
			'{CMD_HWRITE, 8'h00,     13'h0000, 1'b1, ST_HOST},
			'{CMD_HREAD,  8'h00,     13'h1fff, 1'b1, ST_HOST},
			'{CMD_SYNC,   8'h00,     13'h0000, 1'b0, ST_BUSY},
			'{CMD_BYTE,   8'h33,     13'h0000, 1'b1, ST_BAD_ID},
			'{CMD_SYNC,   8'h00,     13'h0000, 1'b0, ST_BUSY},
			'{CMD_BYTE,   ID_DATA,   13'h0000, 1'b1, ST_NO_HDR},
			'{CMD_SYNC,   8'h00,     13'h0000, 1'b0, ST_BUSY},
			'{CMD_BYTE,   ID_HEADER, 13'h0000, 1'b0, ST_BUSY},
			'{CMD_BYTE,   8'h01,     13'h0000, 1'b0, ST_BUSY},
			'{CMD_BYTE,   8'h03,     13'h0000, 1'b0, ST_BUSY},
			'{CMD_BYTE,   8'h01,     13'h0000, 1'b0, ST_BUSY},
			'{CMD_BYTE,   8'h41,     13'h0000, 1'b0, ST_BUSY},
			'{CMD_BYTE,   8'h42,     13'h0000, 1'b1, ST_HDR_OK},
			'{CMD_HREAD,  8'h00,     13'h1fff, 1'b1, ST_HOST},
			'{CMD_BYTE,   GAP_BYTE,  13'h0000, 1'b0, ST_BUSY},
			'{CMD_BYTE,   8'h00,     13'h0000, 1'b1, ST_TRAIL_BAD},
			'{CMD_SYNC,   8'h00,     13'h0000, 1'b0, ST_BUSY},
			'{CMD_BYTE,   ID_HEADER, 13'h0000, 1'b0, ST_BUSY},
			'{CMD_BYTE,   8'h00,     13'h0000, 1'b0, ST_BUSY},
			'{CMD_BYTE,   8'h05,     13'h0000, 1'b0, ST_BUSY},
			'{CMD_BYTE,   8'h01,     13'h0000, 1'b0, ST_BUSY},
			'{CMD_BYTE,   8'h00,     13'h0000, 1'b0, ST_BUSY},
			'{CMD_BYTE,   8'h00,     13'h0000, 1'b1, ST_HDR_SUM},
			'{CMD_ERROR,  8'h00,     13'h0000, 1'b1, ST_BUSY}
		};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			send_beat(plan[i].cmd, plan[i].value, plan[i].addr);
			if (plan[i].typed) begin
				last = pending_reports.pop_back();
				last.st = plan[i].st;
				pending_reports.push_back(last);
			end
		end

		run_phase(0, 32, 1'b0, 500, 1'b1);
		run_phase(83, 1, 1'b0, 200, 1'b0);
		run_phase($urandom_range(0, 83), 32, 1'b1, 300, 1'b0);
		run_phase($urandom_range(0, 83), $urandom_range(1, 32), 1'b1, 250, 1'b0);
		run_phase($urandom_range(0, 83), $urandom_range(1, 32), 1'b0, 200, 1'b0);

		drain();
		repeat (8) @(posedge clk);
		$display("Checked %0d results from %0d beats under %0d register settings.",
			checked, sent, settings);
		$display("Headers ok %0d, sectors read %0d, data sum errors %0d, verify mismatches %0d.",
			hist[ST_HDR_OK], hist[ST_READ], hist[ST_DATA_SUM], hist[ST_MISMATCH]);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

### files.f
sv/gcrssr_pkg.sv
sv/gcrssr_ram.sv
sv/gcr_sector_stream_reader.sv
sim/gcr_sector_stream_reader_test.sv
